[rtl/interval_coverage_accumulator_defines.svh]
// Assertion macros for the interval coverage accumulator.
// Included by the top level; no other dependencies.
`ifndef INTERVAL_COVERAGE_ACCUMULATOR_DEFINES_SVH
`define INTERVAL_COVERAGE_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ICA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ICA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/icov_pkg.sv]
// Shared types, codes and widths for the interval coverage accumulator.
// No dependencies; used by the cell, the controller and the top level.
package icov_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int COORD_W = 31;
    localparam int DEPTH_W = 24;
    localparam int TOTAL_W = 48;
    localparam int PROD_W  = COORD_W + DEPTH_W;
    localparam int SUM_W   = PROD_W + 1;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic [1:0] FUNC_INSERT  = 2'd0;
    localparam logic [1:0] FUNC_SEGMENT = 2'd1;
    localparam logic [1:0] FUNC_FLUSH   = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_ORDER = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_MUL,
        ST_ADD,
        ST_SCAN,
        ST_FIN
    } state_t;

    // One table entry as held by a cell.
    typedef struct packed {
        logic               vld;
        logic               ret;
        logic [COORD_W-1:0] start_c;
        logic [COORD_W-1:0] end_c;
        logic [TOTAL_W-1:0] total;
    } entry_t;

    // Commands and broadcast operands from the controller to every cell.
    typedef struct packed {
        logic               ins;
        logic               calc;
        logic               add;
        logic               shift;
        logic               keep;
        logic [COORD_W-1:0] coord_start;
        logic [COORD_W-1:0] coord_end;
        logic [DEPTH_W-1:0] depth;
    } cell_ctrl_t;

    typedef struct packed {
        logic               valid;
        logic               has_interval;
        logic [COORD_W-1:0] out_start;
        logic [COORD_W-1:0] out_end;
        logic [TOTAL_W-1:0] total;
        logic [1:0]         status;
        logic               last;
    } result_t;

    localparam entry_t ENTRY_EMPTY = '0;

endpackage

[rtl/icov_cell.sv]
// One entry cell of the coverage table: overlap length, product and
// saturating total, plus the shift toward the head. Depends on icov_pkg.
module icov_cell
    import icov_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctl,
    input  logic       prev_vld,
    input  entry_t     nbr,
    input  entry_t     head,
    output entry_t     entry
);

    logic               vld_reg, vld_next;
    entry_t             data_reg, data_next;
    logic [COORD_W-1:0] len_reg, len_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic               overlap;
    logic [COORD_W-1:0] lo, hi;
    logic [SUM_W-1:0]   sum;

    always_comb
    begin
        overlap = vld_reg && (data_reg.start_c < ctl.coord_end)
                  && (data_reg.end_c > ctl.coord_start);
        lo = (data_reg.start_c > ctl.coord_start) ? data_reg.start_c : ctl.coord_start;
        hi = (data_reg.end_c < ctl.coord_end) ? data_reg.end_c : ctl.coord_end;
        len_next = overlap ? (hi - lo) : '0;
        prod_next = PROD_W'(ctl.depth) * PROD_W'(len_reg);
        sum = SUM_W'(data_reg.total) + SUM_W'(prod_reg);
    end

    always_comb
    begin
        vld_next  = vld_reg;
        data_next = data_reg;
        priority if (ctl.ins && !vld_reg && prev_vld)
        begin
            vld_next          = 1'b1;
            data_next.ret     = 1'b0;
            data_next.start_c = ctl.coord_start;
            data_next.end_c   = ctl.coord_end;
            data_next.total   = '0;
        end
        else if (ctl.calc)
        begin
            data_next.ret = (data_reg.end_c <= ctl.coord_end);
        end
        else if (ctl.add)
        begin
            data_next.total = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        end
        else if (ctl.shift)
        begin
            // The last occupied cell takes the head entry back when it is kept.
            if (vld_reg && !nbr.vld && ctl.keep)
            begin
                vld_next      = 1'b1;
                data_next     = head;
                data_next.ret = 1'b0;
            end
            else
            begin
                vld_next  = nbr.vld;
                data_next = nbr;
            end
        end
        else
        begin
            vld_next  = vld_reg;
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        len_reg  <= len_next;
        prod_reg <= prod_next;
    end

    always_comb
    begin
        entry     = data_reg;
        entry.vld = vld_reg;
    end

endmodule

[rtl/icov_ctrl.sv]
// Sequencer of the coverage table: accepts commands, drives the cell row,
// scans retired entries out of the head cell and registers results. Uses icov_pkg.
module icov_ctrl
    import icov_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         func,
    input  logic [COORD_W-1:0] coord_start,
    input  logic [COORD_W-1:0] coord_end,
    input  logic [DEPTH_W-1:0] depth,
    input  entry_t             head,
    output logic               busy,
    output cell_ctrl_t         ctl,
    output result_t            res
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic               all_reg, all_next;
    logic               pend_vld_reg, pend_vld_next;
    entry_t             pend_reg, pend_next;
    logic [COORD_W-1:0] cs_reg, cs_next;
    logic [COORD_W-1:0] ce_reg, ce_next;
    logic [DEPTH_W-1:0] dp_reg, dp_next;
    result_t            res_reg, res_next;
    logic               accept;
    logic               in_order;
    logic               head_out;

    assign accept   = start && (state_reg == ST_IDLE);
    assign in_order = coord_start < coord_end;
    assign head_out = head.ret || all_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && func == FUNC_SEGMENT && in_order)
                begin
                    state_next = ST_CALC;
                end
                else if (accept && func == FUNC_FLUSH)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_CALC: state_next = ST_MUL;
            ST_MUL:  state_next = ST_ADD;
            ST_ADD:  state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (rem_reg == '0)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs toward the cells
    always_comb
    begin
        busy            = (state_reg != ST_IDLE);
        ctl.ins         = accept && func == FUNC_INSERT && in_order && occ_reg != CNT_FULL;
        ctl.calc        = (state_reg == ST_CALC);
        ctl.add         = (state_reg == ST_ADD);
        ctl.shift       = (state_reg == ST_SCAN) && (rem_reg != '0);
        ctl.keep        = !head_out;
        ctl.coord_start = (state_reg == ST_IDLE) ? coord_start : cs_reg;
        ctl.coord_end   = (state_reg == ST_IDLE) ? coord_end : ce_reg;
        ctl.depth       = dp_reg;
    end

    // Counters, held operands and the result beat
    always_comb
    begin
        occ_next      = occ_reg;
        rem_next      = rem_reg;
        all_next      = all_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        cs_next       = cs_reg;
        ce_next       = ce_reg;
        dp_next       = dp_reg;
        res_next      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cs_next       = coord_start;
                    ce_next       = coord_end;
                    dp_next       = depth;
                    all_next      = (func == FUNC_FLUSH);
                    rem_next      = occ_reg;
                    pend_vld_next = 1'b0;
                    if (func == FUNC_INSERT)
                    begin
                        res_next.valid = 1'b1;
                        res_next.last  = 1'b1;
                        if (!in_order)
                        begin
                            res_next.status = STATUS_ORDER;
                        end
                        else if (occ_reg == CNT_FULL)
                        begin
                            res_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            res_next.status = STATUS_OK;
                            occ_next        = occ_reg + 1'b1;
                        end
                    end
                    else if (func == FUNC_SEGMENT && !in_order)
                    begin
                        res_next.valid  = 1'b1;
                        res_next.last   = 1'b1;
                        res_next.status = STATUS_ORDER;
                    end
                end
            end
            ST_ADD:
            begin
                rem_next = occ_reg;
            end
            ST_SCAN:
            begin
                // A retired entry is held until the next one retires or the scan ends, so the final one can carry last.
                if (rem_reg != '0)
                begin
                    rem_next = rem_reg - 1'b1;
                    if (head_out)
                    begin
                        occ_next      = occ_reg - 1'b1;
                        pend_next     = head;
                        pend_vld_next = 1'b1;
                        if (pend_vld_reg)
                        begin
                            res_next.valid        = 1'b1;
                            res_next.has_interval = 1'b1;
                            res_next.out_start    = pend_reg.start_c;
                            res_next.out_end      = pend_reg.end_c;
                            res_next.total        = pend_reg.total;
                        end
                    end
                end
            end
            ST_FIN:
            begin
                res_next.valid = 1'b1;
                res_next.last  = 1'b1;
                if (pend_vld_reg)
                begin
                    res_next.has_interval = 1'b1;
                    res_next.out_start    = pend_reg.start_c;
                    res_next.out_end      = pend_reg.end_c;
                    res_next.total        = pend_reg.total;
                end
                pend_vld_next = 1'b0;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            occ_reg      <= '0;
            rem_reg      <= '0;
            all_reg      <= 1'b0;
            pend_vld_reg <= 1'b0;
            res_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            rem_reg      <= rem_next;
            all_reg      <= all_next;
            pend_vld_reg <= pend_vld_next;
            res_reg      <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        cs_reg   <= cs_next;
        ce_reg   <= ce_next;
        dp_reg   <= dp_next;
    end

    assign res = res_reg;

endmodule

[rtl/interval_coverage_accumulator.sv]
// Top level of the interval coverage accumulator: a row of entry cells and
// the sequencer. Depends on icov_pkg, icov_cell, icov_ctrl and the defines header.
//
//   channel   | handshake            | fields
//   ----------+----------------------+-------------------------------------------
//   command   | start / busy         | func, coord_start, coord_end, depth
//   result    | valid (one cycle)    | has_interval, out_start, out_end, total,
//             |                      | status, last
//
// An insert, a rejected segment and an unused function code leave busy low, so the
// next command may enter at once. The first two give a result beat the cycle after;
// an unused code gives none. A segment keeps busy high through the overlap, multiply
// and add states, then scans the head cell once per stored entry, then finishes.
// A flush keeps busy high through the scan and the finishing state alone.
// Reset empties the table. The receiver cannot stall the result beats.
`include "interval_coverage_accumulator_defines.svh"

module interval_coverage_accumulator
    import icov_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic [COORD_W-1:0] coord_start,
    input  logic [COORD_W-1:0] coord_end,
    input  logic [DEPTH_W-1:0] depth,
    output logic               valid,
    output logic               has_interval,
    output logic [COORD_W-1:0] out_start,
    output logic [COORD_W-1:0] out_end,
    output logic [TOTAL_W-1:0] total,
    output logic [1:0]         status,
    output logic               last
);

    cell_ctrl_t ctl;
    result_t    res;
    entry_t     cells [TABLE_DEPTH];

    icov_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .func        (func),
        .coord_start (coord_start),
        .coord_end   (coord_end),
        .depth       (depth),
        .head        (cells[0]),
        .busy        (busy),
        .ctl         (ctl),
        .res         (res)
    );

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        entry_t nbr;
        logic   prev_vld;

        if (i == TABLE_DEPTH - 1)
        begin : g_tail
            assign nbr = ENTRY_EMPTY;
        end
        else
        begin : g_mid
            assign nbr = cells[i+1];
        end

        if (i == 0)
        begin : g_head
            assign prev_vld = 1'b1;
        end
        else
        begin : g_rest
            assign prev_vld = cells[i-1].vld;
        end

        icov_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .prev_vld (prev_vld),
            .nbr      (nbr),
            .head     (cells[0]),
            .entry    (cells[i])
        );
    end

    assign valid        = res.valid;
    assign has_interval = res.has_interval;
    assign out_start    = res.out_start;
    assign out_end      = res.out_end;
    assign total        = res.total;
    assign status       = res.status;
    assign last         = res.last;

    `ICA_ASSERT_NOW(a_retired_ok, valid && has_interval, status == STATUS_OK, "retired entry with error status")
    `ICA_ASSERT_NOW(a_mid_beat_busy, valid && !last, busy, "non-final beat outside a scan")
    `ICA_ASSERT_NEXT(a_seg_busy, start && !busy && func == FUNC_SEGMENT && coord_start < coord_end, busy && !valid, "segment did not start its pass")

endmodule
